// ===== hw/rtl/ctpr_pkg.sv =====
package ctpr_pkg;

   // image size defaults
   localparam int IMAGE_COLUMNS_DEF = 640;
   localparam int IMAGE_ROWS_DEF    = 480;

   // datapath widths
   localparam int CORDIC_STEPS = 23;
   localparam int ATAN_W       = 22;   // arctangent table entry, Q16 degrees
   localparam int XW           = 45;   // CORDIC x/y
   localparam int AW           = 27;   // angle accumulator, Q16 degrees
   localparam int NW           = 57;   // dividend xr*h
   localparam int DW           = 41;   // divisor zr
   localparam int QW           = 16;   // quotient / range

   // register map
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_COS    = 2'd0;
   localparam logic [1:0] REG_SIN    = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_INVF   = 2'd3;

   localparam logic [14:0] COS_RST    = 15'd25101;
   localparam logic [14:0] SIN_RST    = 15'd21063;
   localparam logic [15:0] HEIGHT_RST = 16'd1104;
   localparam logic [23:0] INVF_RST   = 24'd8777100;

   localparam logic [ATAN_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
      22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
      22'd1
   };

   // one CORDIC + divider step payload
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] ang;
      logic                 zero;
      logic [NW-1:0]        rem;
      logic [DW-1:0]        den;
      logic [QW-1:0]        quo;
      logic                 sat;
   } step_type;

endpackage

// ===== hw/rtl/ctpr_step.sv =====
module ctpr_step #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ctpr_pkg::step_type in_data,
   output logic              out_valid,
   output ctpr_pkg::step_type out_data
);
   import ctpr_pkg::*;

   // divider: step 0 checks saturation, steps 1..16 make quotient bits 15..0
   localparam int K = (IDX >= 1 && IDX <= QW) ? QW - IDX : 0;

   logic               valid_ff;
   step_type           data_ff;
   step_type           data_in;
   logic signed [XW-1:0] x_cur;
   logic signed [XW-1:0] y_cur;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [AW-1:0] atan_s;
   logic [NW-1:0]        trial;

   always_comb begin
      data_in = in_data;
      x_cur   = in_data.x;
      y_cur   = in_data.y;
      xs      = x_cur >>> IDX;
      ys      = y_cur >>> IDX;
      atan_s  = $signed({{(AW-ATAN_W){1'b0}}, ATAN_Q16[IDX]});
      if (y_cur > 0) begin
         data_in.x   = x_cur + ys;
         data_in.y   = y_cur - xs;
         data_in.ang = in_data.ang + atan_s;
      end else begin
         data_in.x   = x_cur - ys;
         data_in.y   = y_cur + xs;
         data_in.ang = in_data.ang - atan_s;
      end
      trial = {{(NW-DW){1'b0}}, in_data.den} << K;
      if (IDX == 0) begin
         data_in.sat = (in_data.rem >= {in_data.den, {QW{1'b0}}});
      end else if (IDX <= QW) begin
         if (!in_data.sat && in_data.rem >= trial) begin
            data_in.rem    = in_data.rem - trial;
            data_in.quo[K] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/camera_pixel_to_target_range_unit.sv =====
// Camera pixel to target range and bearing.
//
// req channel: one target centroid (column, row, pixels Q4) per transfer.
// rsp channel: horizontal range (inches Q12.4, saturated) and bearing
// (degrees Q8, positive to the left). A centroid whose ray, after the mount
// pitch rotation, does not point upward gives no rsp transfer at all.
// APB port: four registers (cos, sin, height difference, 1/focal) at byte
// addresses 0, 4, 8, 12; the user must write them only while the block is idle.
//
// The block does not enforce this write rule. Throughput: one centroid per cycle
// unless rsp_ready stalls. Front end: projection multiply, pitch multiplies,
// shift/rotate, range multiply; then 23 steps, each one CORDIC iteration plus
// a saturation check (step 0) or a restoring divide step (steps 1..16).
//
// Reset clears all valid bits and loads register defaults. When rsp_ready
// is low with a result waiting, the whole pipeline holds (req_ready drops),
// bubbles included; nothing is lost or repeated.
module camera_pixel_to_target_range_unit #(
   parameter int IMAGE_COLUMNS = ctpr_pkg::IMAGE_COLUMNS_DEF,
   parameter int IMAGE_ROWS    = ctpr_pkg::IMAGE_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [13:0]                   req_pixel_column_q4,
   input  logic [12:0]                   req_pixel_row_q4,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_range_q4,
   output logic signed [16:0]            rsp_bearing_q8,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ctpr_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ctpr_pkg::*;

   // image centers in Q4: size/2 pixels minus half a pixel
   localparam logic signed [15:0] CENTER_COL = 16'(IMAGE_COLUMNS * 8 - 8);
   localparam logic signed [15:0] CENTER_ROW = 16'(IMAGE_ROWS * 8 - 8);
   localparam logic signed [AW-1:0] HALF_TURN = AW'(180 * 65536);
   localparam logic signed [AW-1:0] BEAR_MAX  = AW'(46080);

   // ---------------- configuration registers ----------------
   logic [14:0] cos_ff, sin_ff;
   logic [15:0] height_ff;
   logic [23:0] invf_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= COS_RST;
         sin_ff    <= SIN_RST;
         height_ff <= HEIGHT_RST;
         invf_ff   <= INVF_RST;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_COS:    cos_ff    <= pwdata[14:0];
            REG_SIN:    sin_ff    <= pwdata[14:0];
            REG_HEIGHT: height_ff <= pwdata[15:0];
            REG_INVF:   invf_ff   <= pwdata[23:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_COS:    prdata = {17'd0, cos_ff};
         REG_SIN:    prdata = {17'd0, sin_ff};
         REG_HEIGHT: prdata = {16'd0, height_ff};
         REG_INVF:   prdata = {8'd0, invf_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // global hold: everything moves unless a result waits on a stalled receiver
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- stage 1: ray y, z (Q36) ----------------
   logic               v1_ff;
   logic signed [40:0] y1_ff, y1_in, z1_ff, z1_in;
   logic signed [15:0] dcol, drow;
   logic signed [40:0] pcol, prow;

   always_comb begin
      dcol  = $signed({2'b00, req_pixel_column_q4}) - CENTER_COL;
      drow  = $signed({3'b000, req_pixel_row_q4}) - CENTER_ROW;
      pcol  = dcol * $signed({1'b0, invf_ff});
      prow  = drow * $signed({1'b0, invf_ff});
      y1_in = -pcol;
      z1_in = -prow;
   end

   // ---------------- stage 2: pitch products ----------------
   logic               v2_ff;
   logic signed [40:0] y2_ff;
   logic signed [56:0] sz2_ff, sz2_in, cz2_ff, cz2_in;

   always_comb begin
      sz2_in = $signed({1'b0, sin_ff}) * z1_ff;
      cz2_in = $signed({1'b0, cos_ff}) * z1_ff;
   end

   // ---------------- stage 3: rotated xr, zr (floor shift) ----------------
   logic               v3_ff;
   logic signed [40:0] y3_ff;
   logic signed [41:0] xr3_ff, xr3_in, zr3_ff, zr3_in;
   logic signed [56:0] xsum, zsum, xsh, zsh;

   always_comb begin
      xsum   = $signed({1'b0, cos_ff, 36'd0}) - sz2_ff;
      zsum   = cz2_ff + $signed({1'b0, sin_ff, 36'd0});
      xsh    = xsum >>> 15;
      zsh    = zsum >>> 15;
      xr3_in = xsh[41:0];
      zr3_in = zsh[41:0];
   end

   // ---------------- stage 4: range product, CORDIC prerotation ----------------
   // rays that do not point upward are dropped here
   logic               v4_in;
   step_type           s4_in;
   logic signed [XW-1:0] xr_ext, y_ext;
   logic [NW-1:0]        prod;

   always_comb begin
      v4_in  = v3_ff && (zr3_ff > 0);
      xr_ext = XW'(xr3_ff);
      y_ext  = XW'(y3_ff);
      prod   = xr3_ff[40:0] * height_ff;
      s4_in      = '0;
      s4_in.zero = (xr3_ff == 0) && (y3_ff == 0);
      if (xr3_ff < 0) begin
         s4_in.x   = -xr_ext;
         s4_in.y   = -y_ext;
         s4_in.ang = (y3_ff >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
         s4_in.x   = xr_ext;
         s4_in.y   = y_ext;
         s4_in.ang = '0;
      end
      s4_in.rem = (xr3_ff > 0) ? prod : '0;
      s4_in.den = zr3_ff[DW-1:0];
   end

   logic     v4_ff;
   step_type s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v4_in;
      end
      if (en) begin
         y1_ff  <= y1_in;
         z1_ff  <= z1_in;
         y2_ff  <= y1_ff;
         sz2_ff <= sz2_in;
         cz2_ff <= cz2_in;
         y3_ff  <= y2_ff;
         xr3_ff <= xr3_in;
         zr3_ff <= zr3_in;
         s4_ff  <= s4_in;
      end
   end

   // ---------------- CORDIC / divider steps ----------------
   logic     step_v [CORDIC_STEPS+1];
   step_type step_d [CORDIC_STEPS+1];

   assign step_v[0] = v4_ff;
   assign step_d[0] = s4_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      ctpr_step #(.IDX(i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (step_v[i]),
         .in_data   (step_d[i]),
         .out_valid (step_v[i+1]),
         .out_data  (step_d[i+1])
      );
   end

   // ---------------- output register ----------------
   step_type             last;
   logic signed [AW-1:0] ang_rnd, ang_clamp;
   logic [15:0]          range_in;
   logic signed [16:0]   bearing_in;
   logic [15:0]          range_ff;
   logic signed [16:0]   bearing_ff;

   always_comb begin
      last    = step_d[CORDIC_STEPS];
      ang_rnd = (last.ang + AW'(128)) >>> 8;
      if (ang_rnd > BEAR_MAX) begin
         ang_clamp = BEAR_MAX;
      end else if (ang_rnd < -BEAR_MAX) begin
         ang_clamp = -BEAR_MAX;
      end else begin
         ang_clamp = ang_rnd;
      end
      range_in   = last.sat ? {QW{1'b1}} : last.quo;
      bearing_in = last.zero ? 17'sd0 : ang_clamp[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= step_v[CORDIC_STEPS];
      end
      if (en) begin
         range_ff   <= range_in;
         bearing_ff <= bearing_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_range_q4   = range_ff;
   assign rsp_bearing_q8 = bearing_ff;

endmodule

// ===== sim/camera_pixel_to_target_range_unit_tb.sv =====
`timescale 1ns / 100ps

module camera_pixel_to_target_range_unit_tb;
   import ctpr_pkg::*;

   localparam int PIPE_LAT = 28;
   localparam int CYCLE_LIMIT = 400000;

   // lens geometry, image centers in Q4 pixels
   localparam longint CENTER_COL_Q4 = longint'(IMAGE_COLUMNS_DEF / 2) * 16 - 8;
   localparam longint CENTER_ROW_Q4 = longint'(IMAGE_ROWS_DEF / 2) * 16 - 8;

   typedef struct {
      logic [15:0]        range_q4;
      logic signed [16:0] bearing_q8;
   } target_fix_type;

   // arctangent steps, Q16 degrees
   localparam longint ARCTAN_Q16 [23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [13:0] req_pixel_column_q4 = '0;
   logic [12:0] req_pixel_row_q4 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_range_q4;
   logic signed [16:0] rsp_bearing_q8;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // mount geometry as the block should currently hold it
   logic [14:0] geo_cos;
   logic [14:0] geo_sin;
   logic [15:0] geo_height;
   logic [23:0] geo_invf;

   // floor shift (toward minus infinity)
   function automatic longint floor_shr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic logic signed [16:0] aim_bearing(longint x, longint y);
      longint ang;
      longint xs;
      longint ys;
      longint r;
      ang = 0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 23; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (y > 0) begin
            x += ys;
            y -= xs;
            ang += ARCTAN_Q16[i];
         end else begin
            x -= ys;
            y += xs;
            ang -= ARCTAN_Q16[i];
         end
      end
      r = floor_shr(ang + 128, 8);
      if (r > 46080) r = 46080;
      if (r < -46080) r = -46080;
      return r[16:0];
   endfunction

   // returns 1 when the ray points up and a fix is produced
   function automatic bit locate_target(input logic [13:0] col, input logic [12:0] row,
                                        output target_fix_type fix);
      longint y;
      longint z;
      longint xr;
      longint zr;
      longint rng;
      y = -((longint'(col) - CENTER_COL_Q4) * longint'(geo_invf));
      z = -((longint'(row) - CENTER_ROW_Q4) * longint'(geo_invf));
      xr = floor_shr(longint'(geo_cos) * (64'sd1 <<< 36) - longint'(geo_sin) * z, 15);
      zr = floor_shr(longint'(geo_cos) * z + longint'(geo_sin) * (64'sd1 <<< 36), 15);
      if (zr <= 0) return 1'b0;
      rng = 0;
      if (xr > 0) begin
         // xr*h can pass 2^63 only for absurd geometry; use 128-bit product
         rng = longint'((128'(xr) * 128'(geo_height)) / 128'(zr) > 65535 ? 65535 :
                        (128'(xr) * 128'(geo_height)) / 128'(zr));
      end
      fix.range_q4 = rng[15:0];
      fix.bearing_q8 = aim_bearing(xr, y);
      return 1'b1;
   endfunction

   class fix_scoreboard_type;
      target_fix_type pending[$];
      int errors;

      function void note_centroid(logic [13:0] col, logic [12:0] row);
         target_fix_type fix;
         if (locate_target(col, row, fix)) pending = {pending, fix};
      endfunction

      function void check_fix(logic [15:0] rng, logic signed [16:0] brg);
         target_fix_type want;
         if (pending.size() == 0) begin
            $error("unexpected rsp transfer range=%0d bearing=%0d", rng, brg);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (rng !== want.range_q4) begin
            $error("range_q4 expected %0d actual %0d", want.range_q4, rng);
            errors++;
         end
         if (brg !== want.bearing_q8) begin
            $error("bearing_q8 expected %0d actual %0d", want.bearing_q8, brg);
            errors++;
         end
      endfunction
   endclass

   fix_scoreboard_type board = new();

   int rsp_idle_pct = 12;      // receiver stall odds in percent
   int req_idle_pct = 12;      // sender gap odds in percent
   int hold_off_cycles = 0;    // long receiver hold-off, counted on its own
   longint cycle_count = 0;

   camera_pixel_to_target_range_unit uut (.*);

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: check on each transfer
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_fix(rsp_range_q4, rsp_bearing_q8);

   // receiver stalls: random odds, or a long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // one APB write: setup then access, no wait states
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(idx) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_COS:    geo_cos = value[14:0];
         REG_SIN:    geo_sin = value[14:0];
         REG_HEIGHT: geo_height = value[15:0];
         default:    geo_invf = value[23:0];
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic program_mount(logic [31:0] c, logic [31:0] s, logic [31:0] h,
                                logic [31:0] f);
      csr_write(REG_COS, c);
      csr_write(REG_SIN, s);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_INVF, f);
   endtask

   // one req transfer; valid held across back-to-back items
   task automatic send_centroid(logic [13:0] col, logic [12:0] row);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_column_q4 <= col;
      req_pixel_row_q4 <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_centroid(col, row);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      // an item that yields nothing may still be in flight
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   // mostly the sensor area; sometimes the whole field range
   task automatic random_centroids(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            send_centroid(14'($urandom), 13'($urandom));
         else
            send_centroid(14'($urandom_range(10239)), 13'($urandom_range(7679)));
      end
   endtask

   initial begin
      geo_cos = COS_RST;
      geo_sin = SIN_RST;
      geo_height = HEIGHT_RST;
      geo_invf = INVF_RST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, center, out-of-range codes, on reset geometry
      send_centroid(14'd0, 13'd0);
      send_centroid(14'd10239, 13'd7679);
      send_centroid(14'd0, 13'd7679);
      send_centroid(14'd10239, 13'd0);
      send_centroid(14'(CENTER_COL_Q4), 13'(CENTER_ROW_Q4));
      send_centroid(14'd16383, 13'd8191);
      send_centroid(14'd5112, 13'd0);
      send_centroid(14'd0, 13'd3832);
      drain();

      // level mount: zero vector, ray behind, straight behind, saturation
      program_mount(32'd0, 32'd0, 32'd65535, 32'd0);
      send_centroid(14'd100, 13'd100);
      drain();
      program_mount(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_centroid(14'd0, 13'd0);
      send_centroid(14'(CENTER_COL_Q4), 13'd0);
      send_centroid(14'd16383, 13'd0);
      drain();
      program_mount(32'd0, 32'd32767, 32'd65535, 32'd16777215);
      send_centroid(14'(CENTER_COL_Q4), 13'd0);
      send_centroid(14'(CENTER_COL_Q4), 13'd7679);
      send_centroid(14'd0, 13'd0);
      send_centroid(14'd10239, 13'd8191);
      send_centroid(14'(CENTER_COL_Q4), 13'(CENTER_ROW_Q4));
      drain();
      program_mount(32'd32767, 32'd1, 32'd0, 32'd1);
      send_centroid(14'd3000, 13'd200);
      drain();

      // back to reset geometry, random with default stall rates
      program_mount(COS_RST, SIN_RST, HEIGHT_RST, INVF_RST);
      random_centroids(350);

      // long receiver hold-off so the pipeline backs up into req_ready
      hold_off_cycles = 200;
      random_centroids(150);
      drain();

      // no idling stretch, a tilted-up mount and a wide lens
      rsp_idle_pct = 0;
      req_idle_pct = 0;
      program_mount(32'd30000, 32'd13000, 32'd3000, 32'd16000000);
      random_centroids(300);
      drain();

      rsp_idle_pct = 12;
      req_idle_pct = 12;
      program_mount($urandom_range(32767), $urandom_range(32767),
                    $urandom, $urandom);
      random_centroids(300);
      drain();

      program_mount(32'd23170, 32'd23170, 32'd400, 32'd4000000);
      random_centroids(300);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ctpr_pkg.sv
hw/rtl/ctpr_step.sv
hw/rtl/camera_pixel_to_target_range_unit.sv
sim/camera_pixel_to_target_range_unit_tb.sv
